>>> rtl/gbcm_pkg.sv
// ----------------------------------------------------------------------------
// gbcm_pkg
// Shared types, constants and codes of the greedy bounded change maker.
// ----------------------------------------------------------------------------
package gbcm_pkg;

  localparam int MAX_DENOMS = 16;
  localparam int USED_W     = $clog2(MAX_DENOMS + 1);
  localparam int STEP_W     = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
  localparam int VAL_W      = 16;
  localparam int AMT_W      = 32;
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = 4;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_REQ  = 1'b1;

  localparam logic [1:0] STAT_EXACT = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_DIV,
    ST_MUL,
    ST_SUB,
    ST_EMIT,
    ST_STAT
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] stock;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   rotate;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

>>> rtl/gbcm_cell.sv
// ----------------------------------------------------------------------------
// gbcm_cell
// One slot of the denomination chain: sorted insertion and ring rotation.
// ----------------------------------------------------------------------------
module gbcm_cell (
  input  logic                clk,
  input  gbcm_pkg::cell_ctl_t ctl,
  input  logic                occ,
  input  logic                keep_in,
  input  gbcm_pkg::entry_t    prev_entry,
  output gbcm_pkg::entry_t    entry,
  output logic                keep_out
);

  gbcm_pkg::entry_t entry_r;
  gbcm_pkg::entry_t entry_nxt;

  // An occupied slot whose value does not exceed the new one stays put.
  assign keep_out = occ && (entry_r.value <= ctl.new_entry.value);
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.rotate) begin
      entry_nxt = prev_entry;
    end else if (ctl.insert && !keep_out) begin
      entry_nxt = keep_in ? ctl.new_entry : prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> rtl/gbcm_div.sv
// ----------------------------------------------------------------------------
// gbcm_div
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// ----------------------------------------------------------------------------
module gbcm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [gbcm_pkg::VAL_W-1:0]   num_hi,
  input  logic [gbcm_pkg::VAL_W-1:0]   num_lo,
  input  logic [gbcm_pkg::VAL_W-1:0]   den,
  output logic                         done,
  output logic [gbcm_pkg::VAL_W-1:0]   quot,
  output logic [gbcm_pkg::VAL_W-1:0]   rem
);

  logic                             active_r, active_nxt;
  logic [gbcm_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [gbcm_pkg::VAL_W-1:0]       p_r, p_nxt;
  logic [gbcm_pkg::VAL_W-1:0]       lo_r, lo_nxt;
  logic [gbcm_pkg::VAL_W:0]         trial;
  logic                             ge;

  // The partial remainder stays below the divisor, so it fits 16 bits.
  assign trial = {p_r, lo_r[gbcm_pkg::VAL_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign done  = active_r && (cnt_r == gbcm_pkg::DIV_CNT_W'(gbcm_pkg::DIV_STEPS - 1));
  assign quot  = {lo_r[gbcm_pkg::VAL_W-2:0], ge};
  assign rem   = ge ? gbcm_pkg::VAL_W'(trial - {1'b0, den}) : trial[gbcm_pkg::VAL_W-1:0];

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    p_nxt      = p_r;
    lo_nxt     = lo_r;
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
      p_nxt      = num_hi;
      lo_nxt     = num_lo;
    end else if (active_r) begin
      p_nxt   = rem;
      lo_nxt  = quot;
      cnt_nxt = cnt_r + 1'b1;
      if (done) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r  <= p_nxt;
    lo_r <= lo_nxt;
  end

endmodule

>>> rtl/greedy_bounded_change_maker_top.sv
// ----------------------------------------------------------------------------
// greedy_bounded_change_maker_top
// Greedy change maker over a sorted, stocked ring of denomination cells.
// ----------------------------------------------------------------------------
// A load inserts its entry; into a full table it gives a STAT_FULL status item. A request
// makes MAX_DENOMS ring steps: an empty slot is only rotated; a zero face is emitted with
// its whole stock; when the remainder holds 65536 or more of the face, the stock goes
// through multiply and subtract; else the bit-serial divider gives the count, with multiply
// and subtract if the stock caps it. Items go one at a time, and output stalls hold them.
// Reset clears the entry count, the sequencer and the output valid; cell data stays.
// ----------------------------------------------------------------------------
module greedy_bounded_change_maker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // coin_value[15:0], coin_count[31:16], amount[63:32]
  input  logic [0:0]  in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_value[15:0], out_count[31:16], status[33:32], zero
  output logic [0:0]  out_tuser,  // is_status[0]
  output logic        out_tlast
);

  localparam int MAXD = gbcm_pkg::MAX_DENOMS;
  localparam int UW   = gbcm_pkg::USED_W;
  localparam int SW   = gbcm_pkg::STEP_W;
  localparam int VW   = gbcm_pkg::VAL_W;
  localparam int AW   = gbcm_pkg::AMT_W;

  gbcm_pkg::state_t    state_r, state_nxt;
  logic [UW-1:0]       used_r, used_nxt;
  logic [SW-1:0]       step_r, step_nxt;
  logic [AW-1:0]       rem_r, rem_nxt;
  logic [VW-1:0]       take_r, take_nxt;
  logic [AW-1:0]       prod_r, prod_nxt;
  logic [1:0]          stat_r, stat_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VW-1:0]       out_value_r, out_value_nxt;
  logic [VW-1:0]       out_count_r, out_count_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic                out_user_r, out_user_nxt;
  logic                out_last_r, out_last_nxt;

  gbcm_pkg::cell_ctl_t ctl;
  gbcm_pkg::entry_t    entries [MAXD];
  logic [MAXD-1:0]     keeps;
  logic [MAXD-1:0]     occ;
  gbcm_pkg::entry_t    head;
  gbcm_pkg::entry_t    wb_entry;
  logic [VW-1:0]       wb_stock;

  logic                in_fire;
  logic                out_free;
  logic                head_occ;
  logic                last_step;
  gbcm_pkg::state_t    adv_state;
  logic [SW-1:0]       adv_step;
  logic [1:0]          adv_stat;

  logic                div_start;
  logic                div_done;
  logic [VW-1:0]       div_quot;
  logic [VW-1:0]       div_rem;

  assign in_tready  = (state_r == gbcm_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_status_r, out_count_r, out_value_r};
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign head     = entries[MAXD-1];
  assign wb_entry = '{value: head.value, stock: wb_stock};
  assign head_occ = ((UW+1)'(step_r) + (UW+1)'(used_r)) >= (UW+1)'(MAXD);

  assign last_step = (step_r == SW'(MAXD - 1));
  assign adv_state = last_step ? gbcm_pkg::ST_STAT : gbcm_pkg::ST_HEAD;
  assign adv_step  = last_step ? '0 : SW'(step_r + 1'b1);
  assign adv_stat  = (rem_r != '0) ? gbcm_pkg::STAT_SHORT : gbcm_pkg::STAT_EXACT;

  for (genvar g = 0; g < MAXD; g++) begin : g_cell
    assign occ[g] = (used_r > UW'(g));
    if (g == 0) begin : g_first
      gbcm_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (occ[g]),
        .keep_in    (1'b1),
        .prev_entry (wb_entry),
        .entry      (entries[g]),
        .keep_out   (keeps[g])
      );
    end else begin : g_rest
      gbcm_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (occ[g]),
        .keep_in    (keeps[g-1]),
        .prev_entry (entries[g-1]),
        .entry      (entries[g]),
        .keep_out   (keeps[g])
      );
    end
  end

  gbcm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_hi (rem_r[AW-1:VW]),
    .num_lo (rem_r[VW-1:0]),
    .den    (head.value),
    .done   (div_done),
    .quot   (div_quot),
    .rem    (div_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    step_nxt       = step_r;
    rem_nxt        = rem_r;
    take_nxt       = take_r;
    prod_nxt       = prod_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    out_user_nxt   = out_user_r;
    out_last_nxt   = out_last_r;
    ctl.insert          = 1'b0;
    ctl.rotate          = 1'b0;
    ctl.new_entry.value = in_tdata[15:0];
    ctl.new_entry.stock = in_tdata[31:16];
    wb_stock       = head.stock;
    div_start      = 1'b0;
    unique case (state_r)
      gbcm_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == gbcm_pkg::FUNC_LOAD) begin
            if (used_r == UW'(MAXD)) begin
              stat_nxt  = gbcm_pkg::STAT_FULL;
              state_nxt = gbcm_pkg::ST_STAT;
            end else begin
              ctl.insert = 1'b1;
              used_nxt   = used_r + 1'b1;
            end
          end else begin
            rem_nxt   = in_tdata[63:32];
            step_nxt  = '0;
            state_nxt = gbcm_pkg::ST_HEAD;
          end
        end
      end
      gbcm_pkg::ST_HEAD: begin
        if (!head_occ) begin
          ctl.rotate = 1'b1;
          step_nxt   = adv_step;
          stat_nxt   = adv_stat;
          state_nxt  = adv_state;
        end else if (head.value == '0) begin
          take_nxt  = head.stock;
          state_nxt = gbcm_pkg::ST_EMIT;
        end else if (rem_r[AW-1:VW] >= head.value) begin
          take_nxt  = head.stock;
          state_nxt = gbcm_pkg::ST_MUL;
        end else begin
          div_start = 1'b1;
          state_nxt = gbcm_pkg::ST_DIV;
        end
      end
      gbcm_pkg::ST_DIV: begin
        if (div_done) begin
          if (div_quot <= head.stock) begin
            take_nxt  = div_quot;
            rem_nxt   = AW'(div_rem);
            state_nxt = gbcm_pkg::ST_EMIT;
          end else begin
            take_nxt  = head.stock;
            state_nxt = gbcm_pkg::ST_MUL;
          end
        end
      end
      gbcm_pkg::ST_MUL: begin
        prod_nxt  = AW'(take_r) * AW'(head.value);
        state_nxt = gbcm_pkg::ST_SUB;
      end
      gbcm_pkg::ST_SUB: begin
        rem_nxt   = rem_r - prod_r;
        state_nxt = gbcm_pkg::ST_EMIT;
      end
      gbcm_pkg::ST_EMIT: begin
        if (take_r == '0) begin
          ctl.rotate = 1'b1;
          step_nxt   = adv_step;
          stat_nxt   = adv_stat;
          state_nxt  = adv_state;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = head.value;
          out_count_nxt  = take_r;
          out_status_nxt = gbcm_pkg::STAT_EXACT;
          out_user_nxt   = 1'b0;
          out_last_nxt   = 1'b0;
          wb_stock       = head.stock - take_r;
          ctl.rotate     = 1'b1;
          step_nxt       = adv_step;
          stat_nxt       = adv_stat;
          state_nxt      = adv_state;
        end
      end
      gbcm_pkg::ST_STAT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_count_nxt  = '0;
          out_status_nxt = stat_r;
          out_user_nxt   = 1'b1;
          out_last_nxt   = 1'b1;
          state_nxt      = gbcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gbcm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbcm_pkg::ST_IDLE;
      used_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    take_r       <= take_nxt;
    prod_r       <= prod_nxt;
    stat_r       <= stat_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
    out_user_r   <= out_user_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_used_bound : assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(MAXD))
    else $error("Entry count exceeds the table size.");

  a_status_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("Status item is not marked last.");

  a_idle_step : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gbcm_pkg::ST_IDLE |-> step_r == '0)
    else $error("Ring step count not back at zero when idle.");

  a_full_load : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tuser[0] == gbcm_pkg::FUNC_LOAD) && (used_r == UW'(MAXD))
    |=> (state_r == gbcm_pkg::ST_STAT) && (stat_r == gbcm_pkg::STAT_FULL))
    else $error("Load into a full table did not raise the full status.");

endmodule
